/* src/tof_distance_filter_emergency_defines.svh */
// Assertion macros shared by the property checker of the distance filter.
// Both macros sample on clk and are disabled while arst_n is low.
`ifndef TOF_DISTANCE_FILTER_EMERGENCY_DEFINES_SVH
`define TOF_DISTANCE_FILTER_EMERGENCY_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TDFE_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tdfe: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define TDFE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tdfe: next-cycle property failed");

`endif

/* src/tdfe_pkg.sv */
package tdfe_pkg;

	// Ring depth of the moving average and the widths that follow from it.
	localparam int AVG_DEPTH = 8;
	localparam int NUM_CH    = 3;
	localparam int DIST_W    = 16;
	localparam int LIM_W     = 13;
	localparam int CFG_IDX_W = 3;
	localparam int SLOT_W    = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
	localparam int CNT_W     = $clog2(AVG_DEPTH + 1);
	localparam int SUM_W     = DIST_W + $clog2(AVG_DEPTH);
	localparam int BIT_W     = $clog2(SUM_W);

	// Reading substituted for a timed-out channel, and the validity bound.
	localparam logic [DIST_W-1:0] TIMEOUT_VALUE = 16'd8190;
	localparam logic [DIST_W-1:0] VALID_BELOW   = 16'd8000;

	// Register reset values.
	localparam logic [LIM_W-1:0] WALL_LIMIT_RST      = 13'd100;
	localparam logic [LIM_W-1:0] EMERGENCY_LIMIT_RST = 13'd20;
	localparam logic [LIM_W-1:0] REARM_LIMIT_RST     = 13'd40;
	localparam logic [LIM_W-1:0] LEFT_OFFSET_RST     = 13'd0;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WALL_LIMIT      = 3'd0,
		REG_EMERGENCY_LIMIT = 3'd1,
		REG_REARM_LIMIT     = 3'd2,
		REG_LEFT_OFFSET     = 3'd3
	} cfg_reg_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_DIVIDE,
		ST_DONE
	} state_t;

	// One word per ring slot: left, front, right.
	typedef logic [NUM_CH-1:0][DIST_W-1:0] lanes_t;

	typedef struct packed {
		logic [DIST_W-1:0] dist_left;
		logic [DIST_W-1:0] dist_front;
		logic [DIST_W-1:0] dist_right;
		logic [2:0]        timeouts;
	} sample_t;

	typedef struct packed {
		logic [DIST_W-1:0] avg_left;
		logic [DIST_W-1:0] avg_front;
		logic [DIST_W-1:0] avg_right;
		logic [2:0]        wall_mask;
		logic [2:0]        wall_changed;
		logic              emergency_active;
		logic [2:0]        emergency_sides;
		logic              stop_motors;
	} result_t;

endpackage

/* src/tof_distance_filter_emergency.sv */
// Each accepted sample passes through the update, divide and done states; the bit-serial
// dividers turn the three running sums into averages, one quotient bit per cycle.
// A new sample is taken only in the idle state, once the previous result has been loaded.
// A sample may be accepted while the previous result still waits in the output register.
// Asynchronous active-low reset clears sums, ring pointer, fill flag, alarm and wall
// state and loads the register defaults; the ring memory itself is not cleared.
module tof_distance_filter_emergency (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             sample_valid,
	output logic                             sample_stall,
	input  tdfe_pkg::sample_t                sample,
	output logic                             result_valid,
	input  logic                             result_stall,
	output tdfe_pkg::result_t                result,
	input  logic                             cfg_we,
	input  logic [tdfe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tdfe_pkg::LIM_W-1:0]       cfg_data
);

	localparam int DW = tdfe_pkg::DIST_W;
	localparam int SW = tdfe_pkg::SUM_W;
	localparam int CW = tdfe_pkg::CNT_W;

	tdfe_pkg::state_t state_q, state_d;

	logic [tdfe_pkg::LIM_W-1:0] wall_limit_q, emergency_limit_q, rearm_limit_q;
	logic [tdfe_pkg::LIM_W-1:0] left_offset_q;

	tdfe_pkg::lanes_t ring_mem [tdfe_pkg::AVG_DEPTH];
	tdfe_pkg::lanes_t rd_q;
	tdfe_pkg::lanes_t val_q;
	tdfe_pkg::lanes_t latest_q;
	tdfe_pkg::lanes_t raw;
	tdfe_pkg::lanes_t avg;

	logic [tdfe_pkg::NUM_CH-1:0][SW-1:0] sum_q, sum_next;
	logic [tdfe_pkg::NUM_CH-1:0][SW-1:0] quot_q;
	logic [tdfe_pkg::NUM_CH-1:0][CW-1:0] rem_q;

	logic [tdfe_pkg::SLOT_W-1:0] slot_q, slot_next;
	logic                        full_q, full_next, slot_wrap;
	logic [CW-1:0]               den_q, den_next;
	logic [tdfe_pkg::BIT_W-1:0]  bit_q;

	logic       alarm_q;
	logic [2:0] alarm_sides_q;
	logic [2:0] wall_seen_q;
	logic [2:0] near_emerg, near_rearm, walls;

	logic signed [DW+1:0] left_sum;
	logic [DW-1:0]        left_corr;

	logic              sample_accept, out_load;
	logic              out_valid_q;
	tdfe_pkg::result_t out_q, result_d;

	assign sample_accept = sample_valid && !sample_stall;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wall_limit_q      <= tdfe_pkg::WALL_LIMIT_RST;
			emergency_limit_q <= tdfe_pkg::EMERGENCY_LIMIT_RST;
			rearm_limit_q     <= tdfe_pkg::REARM_LIMIT_RST;
			left_offset_q     <= tdfe_pkg::LEFT_OFFSET_RST;
		end else if (cfg_we) begin
			unique case (tdfe_pkg::cfg_reg_t'(cfg_index))
				tdfe_pkg::REG_WALL_LIMIT:      wall_limit_q      <= cfg_data;
				tdfe_pkg::REG_EMERGENCY_LIMIT: emergency_limit_q <= cfg_data;
				tdfe_pkg::REG_REARM_LIMIT:     rearm_limit_q     <= cfg_data;
				tdfe_pkg::REG_LEFT_OFFSET:     left_offset_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Timeout substitution and left offset with a clamp at zero; invalid left readings pass unchanged.
	always_comb begin
		raw[0] = sample.timeouts[0] ? tdfe_pkg::TIMEOUT_VALUE : sample.dist_left;
		raw[1] = sample.timeouts[1] ? tdfe_pkg::TIMEOUT_VALUE : sample.dist_front;
		raw[2] = sample.timeouts[2] ? tdfe_pkg::TIMEOUT_VALUE : sample.dist_right;
		left_sum = $signed({2'b00, raw[0]})
			+ $signed({{(DW + 2 - tdfe_pkg::LIM_W){left_offset_q[tdfe_pkg::LIM_W-1]}},
				left_offset_q});
		if (raw[0] >= tdfe_pkg::VALID_BELOW) begin
			left_corr = raw[0];
		end else if (left_sum[DW+1] || left_sum == '0) begin
			left_corr = '0;
		end else begin
			left_corr = left_sum[DW-1:0];
		end
	end

	// Ring memory: the old entry of the slot is read when the request is taken,
	// and the new sample is written back in the update cycle.
	always_ff @(posedge clk) begin
		if (sample_accept) begin
			rd_q <= ring_mem[slot_q];
		end
		if (state_q == tdfe_pkg::ST_UPDATE) begin
			ring_mem[slot_q] <= val_q;
		end
	end

	// Captured sample for the update cycle.
	always_ff @(posedge clk) begin
		if (sample_accept) begin
			val_q <= {raw[2], raw[1], left_corr};
		end
	end

	// Running sums, ring pointer and divisor for the averages.
	always_comb begin
		for (int i = 0; i < tdfe_pkg::NUM_CH; i++) begin
			sum_next[i] = sum_q[i]
				- (full_q ? {{(SW - DW){1'b0}}, rd_q[i]} : '0)
				+ {{(SW - DW){1'b0}}, val_q[i]};
		end
		slot_wrap = (slot_q == tdfe_pkg::SLOT_W'(tdfe_pkg::AVG_DEPTH - 1));
		slot_next = slot_wrap ? '0 : slot_q + 1'b1;
		full_next = full_q || slot_wrap;
		den_next  = full_next ? CW'(tdfe_pkg::AVG_DEPTH) : CW'(slot_next);
	end

	// Proximity of the latest readings to the emergency and rearm limits.
	always_comb begin
		for (int i = 0; i < tdfe_pkg::NUM_CH; i++) begin
			near_emerg[i] = (latest_q[i] < tdfe_pkg::VALID_BELOW)
				&& (latest_q[i] <= {{(DW - tdfe_pkg::LIM_W){1'b0}}, emergency_limit_q});
			near_rearm[i] = (latest_q[i] < tdfe_pkg::VALID_BELOW)
				&& (latest_q[i] <= {{(DW - tdfe_pkg::LIM_W){1'b0}}, rearm_limit_q});
		end
	end

	// Filter state, latest readings and the latched emergency.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q         <= '0;
			slot_q        <= '0;
			full_q        <= 1'b0;
			latest_q      <= {tdfe_pkg::TIMEOUT_VALUE, tdfe_pkg::TIMEOUT_VALUE,
				tdfe_pkg::TIMEOUT_VALUE};
			alarm_q       <= 1'b0;
			alarm_sides_q <= '0;
			wall_seen_q   <= '0;
		end else begin
			if (sample_accept) begin
				latest_q <= {raw[2], raw[1], left_corr};
			end
			if (state_q == tdfe_pkg::ST_UPDATE) begin
				sum_q  <= sum_next;
				slot_q <= slot_next;
				full_q <= full_next;
				if (near_emerg != '0) begin
					alarm_q       <= 1'b1;
					alarm_sides_q <= near_emerg;
				end else if (alarm_q && near_rearm == '0) begin
					alarm_q       <= 1'b0;
					alarm_sides_q <= '0;
				end
			end
			if (out_load) begin
				wall_seen_q <= walls;
			end
		end
	end

	// Three bit-serial restoring dividers, one quotient bit per cycle.
	always_ff @(posedge clk) begin
		if (state_q == tdfe_pkg::ST_UPDATE) begin
			quot_q <= sum_next;
			rem_q  <= '0;
			den_q  <= den_next;
		end else if (state_q == tdfe_pkg::ST_DIVIDE) begin
			for (int i = 0; i < tdfe_pkg::NUM_CH; i++) begin
				logic [CW:0] trial;
				logic        ge;
				trial = {rem_q[i], quot_q[i][SW-1]};
				ge    = (trial >= {1'b0, den_q});
				rem_q[i]  <= ge ? CW'(trial - {1'b0, den_q}) : CW'(trial);
				quot_q[i] <= {quot_q[i][SW-2:0], ge};
			end
		end
	end

	// Divider bit counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= '0;
		end else if (state_q == tdfe_pkg::ST_UPDATE) begin
			bit_q <= tdfe_pkg::BIT_W'(SW - 1);
		end else if (state_q == tdfe_pkg::ST_DIVIDE) begin
			bit_q <= bit_q - 1'b1;
		end
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tdfe_pkg::ST_IDLE:   if (sample_accept) state_d = tdfe_pkg::ST_UPDATE;
			tdfe_pkg::ST_UPDATE: state_d = tdfe_pkg::ST_DIVIDE;
			tdfe_pkg::ST_DIVIDE: if (bit_q == '0) state_d = tdfe_pkg::ST_DONE;
			tdfe_pkg::ST_DONE:   if (out_load) state_d = tdfe_pkg::ST_IDLE;
			default:             state_d = tdfe_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tdfe_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer outputs.
	always_comb begin
		sample_stall = (state_q != tdfe_pkg::ST_IDLE);
		out_load     = (state_q == tdfe_pkg::ST_DONE) && (!out_valid_q || !result_stall);
	end

	// Averages, wall detection and result assembly.
	always_comb begin
		for (int i = 0; i < tdfe_pkg::NUM_CH; i++) begin
			avg[i]   = quot_q[i][DW-1:0];
			walls[i] = (avg[i] < {{(DW - tdfe_pkg::LIM_W){1'b0}}, wall_limit_q});
		end
		result_d.avg_left         = avg[0];
		result_d.avg_front        = avg[1];
		result_d.avg_right        = avg[2];
		result_d.wall_mask        = walls;
		result_d.wall_changed     = walls ^ wall_seen_q;
		result_d.emergency_active = alarm_q;
		result_d.emergency_sides  = alarm_sides_q;
		result_d.stop_motors      = alarm_q;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= result_d;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

/* src/tdfe_props.sv */
`include "tof_distance_filter_emergency_defines.svh"

// Port-level properties of the distance filter.
module tdfe_props (
	input logic              clk,
	input logic              arst_n,
	input logic              sample_valid,
	input logic              sample_stall,
	input logic              result_valid,
	input logic              result_stall,
	input tdfe_pkg::result_t result
);

	// The stop request mirrors the latched emergency.
	`TDFE_ASSERT_SAME(a_stop_follows_emergency, result_valid, result.stop_motors == result.emergency_active)

	// A latched emergency always names at least one side, a clear one names none.
	`TDFE_ASSERT_SAME(a_sides_match_latch, result_valid, (result.emergency_sides != 3'b000) == result.emergency_active)

	// A taken request keeps the block busy in the following cycle.
	`TDFE_ASSERT_NEXT(a_busy_after_request, sample_valid && !sample_stall, sample_stall)

	// A stalled result stays valid and unchanged.
	`TDFE_ASSERT_NEXT(a_result_holds, result_valid && result_stall, result_valid && $stable(result))

endmodule

bind tof_distance_filter_emergency tdfe_props u_tdfe_props (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample_valid),
	.sample_stall (sample_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
